// ===== rtl/eod_pkg.sv =====
package eod_pkg;

    localparam int FLOOR_COUNT = 4;

    // floors shown on the lamp field
    localparam int LAMP_FLOORS = (FLOOR_COUNT < 4) ? FLOOR_COUNT : 4;

    // width of a floor number inside the block, wide enough for the top floor
    localparam int HERE_W = (FLOOR_COUNT > 4) ? $clog2(FLOOR_COUNT) : 2;

    localparam logic [1:0] ACT_SET       = 2'd0;
    localparam logic [1:0] ACT_CLR_FLOOR = 2'd1;
    localparam logic [1:0] ACT_CLR_ALL   = 2'd2;
    localparam logic [1:0] ACT_EVAL      = 2'd3;

    localparam logic [1:0] BTN_UP    = 2'd0;
    localparam logic [1:0] BTN_DOWN  = 2'd1;
    localparam logic [1:0] BTN_CABIN = 2'd2;
    // button code that names no order kind
    localparam logic [1:0] BTN_NONE  = 2'd3;

    // bit positions of one floor's order word
    localparam int ORD_UP    = 0;
    localparam int ORD_DOWN  = 1;
    localparam int ORD_CABIN = 2;

    localparam logic [1:0] DIR_UP   = 2'd0;
    localparam logic [1:0] DIR_DOWN = 2'd1;
    localparam logic [1:0] DIR_KEEP = 2'd2;

    typedef logic [2:0] t_orders;
    typedef t_orders [FLOOR_COUNT-1:0] t_table;

    typedef struct packed {
        logic [1:0] action;
        logic [1:0] floor;
        logic [1:0] button;
        logic       travel_down;
    } t_item;

    typedef struct packed {
        logic        stop_here;
        logic        orders_empty;
        logic [1:0]  next_direction;
        logic        restart_direction;
        logic [11:0] order_lamps;
    } t_result;

    function automatic logic floor_in_range(input logic [1:0] floor);
        return int'(floor) < FLOOR_COUNT;
    endfunction

endpackage

// ===== rtl/eod_if.sv =====
interface eod_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [1:0] floor;
    logic [1:0] button;
    logic       travel_down;

    modport source (output valid, action, floor, button, travel_down, input ready);
    modport sink   (input valid, action, floor, button, travel_down, output ready);
endinterface

interface eod_out_if;
    logic        valid;
    logic        ready;
    logic        stop_here;
    logic        orders_empty;
    logic [1:0]  next_direction;
    logic        restart_direction;
    logic [11:0] order_lamps;

    modport source (output valid, stop_here, orders_empty, next_direction,
                    restart_direction, order_lamps, input ready);
    modport sink   (input valid, stop_here, orders_empty, next_direction,
                    restart_direction, order_lamps, output ready);
endinterface

// ===== rtl/elevator_order_dispatcher_core.sv =====
// channel  | dir | handshake     | payload
// i_in     | in  | valid / ready | action, floor, button, travel_down
// o_out    | out | valid / ready | stop_here, orders_empty, next_direction,
//          |     |               | restart_direction, order_lamps
//
// one item per cycle unless a stalled result holds it back; a taken item passes through
// the input register, then order table update and decision into the result register
// the order table is cleared by the synchronous reset
// a stalled result register holds the input register; i_in.ready drops only
// when both are full and o_out.ready is low
module elevator_order_dispatcher_core (
    input  logic   i_clk,
    input  logic   i_rst_n,
    eod_in_if.sink     i_in,
    eod_out_if.source  o_out
);
    import eod_pkg::*;

    logic    r_in_vld;
    t_item   r_item;
    logic    r_out_vld;
    t_result r_res;
    t_result n_res;
    t_table  table_next;
    logic    advance;

    assign advance  = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || advance;

    eod_order_table u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (advance),
        .i_item       (r_item),
        .o_table_next (table_next)
    );

    eod_decide u_decide (
        .i_table       (table_next),
        .i_floor       (r_item.floor),
        .i_travel_down (r_item.travel_down),
        .o_result      (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.action      <= i_in.action;
            r_item.floor       <= i_in.floor;
            r_item.button      <= i_in.button;
            r_item.travel_down <= i_in.travel_down;
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid             = r_out_vld;
    assign o_out.stop_here         = r_res.stop_here;
    assign o_out.orders_empty      = r_res.orders_empty;
    assign o_out.next_direction    = r_res.next_direction;
    assign o_out.restart_direction = r_res.restart_direction;
    assign o_out.order_lamps       = r_res.order_lamps;

endmodule

// ===== rtl/eod_order_table.sv =====
module eod_order_table (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  eod_pkg::t_item  i_item,
    output eod_pkg::t_table o_table_next
);
    import eod_pkg::*;

    t_table r_table;
    t_table n_table;
    logic   set_ok;

    // nonexistent hall calls and the unused button code are dropped
    assign set_ok = floor_in_range(i_item.floor)
                    && (i_item.button != BTN_NONE)
                    && !(i_item.button == BTN_UP && int'(i_item.floor) == FLOOR_COUNT - 1)
                    && !(i_item.button == BTN_DOWN && i_item.floor == 2'd0);

    always_comb begin
        n_table = r_table;
        case (i_item.action)
            ACT_SET: begin
                if (set_ok) begin
                    for (int f = 0; f < FLOOR_COUNT; f++) begin
                        if (int'(i_item.floor) == f) begin
                            n_table[f][i_item.button] = 1'b1;
                        end
                    end
                end
            end
            ACT_CLR_FLOOR: begin
                for (int f = 0; f < FLOOR_COUNT; f++) begin
                    if (int'(i_item.floor) == f) begin
                        n_table[f] = '0;
                    end
                end
            end
            ACT_CLR_ALL: begin
                n_table = '0;
            end
            ACT_EVAL: begin
                n_table = r_table;
            end
            default: begin
                n_table = r_table;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table <= '0;
        end else if (i_en) begin
            r_table <= n_table;
        end
    end

    assign o_table_next = n_table;

endmodule

// ===== rtl/eod_decide.sv =====
module eod_decide (
    input  eod_pkg::t_table  i_table,
    input  logic [1:0]       i_floor,
    input  logic             i_travel_down,
    output eod_pkg::t_result o_result
);
    import eod_pkg::*;

    logic              in_range;
    logic [HERE_W-1:0] here;
    t_orders           at_floor;
    logic              any_order;
    logic              p1_hit;
    logic              p2_hit;
    logic              p2_side;
    logic              p3_hit;
    logic              restart_hit;
    logic [11:0]       lamps;
    logic [1:0]        next_dir;

    assign in_range = floor_in_range(i_floor);
    assign here     = in_range ? HERE_W'(i_floor) : HERE_W'(FLOOR_COUNT - 1);

    always_comb begin
        at_floor  = '0;
        any_order = 1'b0;
        lamps     = '0;
        for (int f = 0; f < FLOOR_COUNT; f++) begin
            if (int'(i_floor) == f) begin
                at_floor = i_table[f];
            end
            any_order = any_order | (|i_table[f]);
        end
        for (int f = 0; f < LAMP_FLOORS; f++) begin
            lamps[3*f +: 3] = i_table[f];
        end
    end

    // three-pass sweep; the second pass keeps the last hit of its scan order
    always_comb begin
        p1_hit      = 1'b0;
        p2_hit      = 1'b0;
        p2_side     = 1'b0;
        p3_hit      = 1'b0;
        restart_hit = 1'b0;
        if (!i_travel_down) begin
            for (int f = 0; f < FLOOR_COUNT; f++) begin
                if (f >= int'(here) && (i_table[f][ORD_UP] || i_table[f][ORD_CABIN])) begin
                    p1_hit = 1'b1;
                end
                // highest down or cabin order
                if (i_table[f][ORD_DOWN] || i_table[f][ORD_CABIN]) begin
                    p2_hit  = 1'b1;
                    p2_side = (f > int'(here));
                end
                if (f < int'(here) && i_table[f][ORD_UP]) begin
                    p3_hit = 1'b1;
                end
                if (f <= int'(here) && (|i_table[f])) begin
                    restart_hit = 1'b1;
                end
            end
        end else begin
            for (int f = FLOOR_COUNT - 1; f >= 0; f--) begin
                if (f <= int'(here) && (i_table[f][ORD_DOWN] || i_table[f][ORD_CABIN])) begin
                    p1_hit = 1'b1;
                end
                // lowest up or cabin order
                if (i_table[f][ORD_UP] || i_table[f][ORD_CABIN]) begin
                    p2_hit  = 1'b1;
                    p2_side = (f < int'(here));
                end
                if (f > int'(here) && i_table[f][ORD_DOWN]) begin
                    p3_hit = 1'b1;
                end
                if (f < int'(here) && (|i_table[f])) begin
                    restart_hit = 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (p1_hit) begin
            next_dir = i_travel_down ? DIR_DOWN : DIR_UP;
        end else if (p2_hit) begin
            if (i_travel_down) begin
                next_dir = p2_side ? DIR_DOWN : DIR_UP;
            end else begin
                next_dir = p2_side ? DIR_UP : DIR_DOWN;
            end
        end else if (p3_hit) begin
            next_dir = i_travel_down ? DIR_UP : DIR_DOWN;
        end else begin
            next_dir = DIR_KEEP;
        end
    end

    always_comb begin
        o_result.stop_here = in_range && (at_floor[ORD_CABIN]
                             || (i_travel_down ? at_floor[ORD_DOWN] : at_floor[ORD_UP]));
        o_result.orders_empty      = !any_order;
        o_result.next_direction    = next_dir;
        o_result.restart_direction = restart_hit ? DIR_DOWN[0] : DIR_UP[0];
        o_result.order_lamps       = lamps;
    end

endmodule

// ===== tb/sv/elevator_order_dispatcher_core_tb.sv =====
module elevator_order_dispatcher_core_tb;
    import eod_pkg::*;

    localparam int TOP_FLOOR = FLOOR_COUNT - 1;
    localparam int DRAIN_LIMIT = 2000;

    logic i_clk;
    logic i_rst_n;

    eod_in_if  in_ch ();
    eod_out_if out_ch ();

    elevator_order_dispatcher_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // predicted order table and the results still owed by the block
    logic [2:0] order_table [FLOOR_COUNT];
    t_result    owed_results [$];

    bit idle_on;
    int fail_count;
    int items_sent;
    int results_checked;
    int dir_seen [3];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("elevator_order_dispatcher_core_tb failed");
        $finish;
    end

    function automatic logic [1:0] sweep_dir(input int here, input logic down);
        if (!down) begin
            for (int f = here; f <= TOP_FLOOR; f++)
                if (order_table[f][ORD_UP] || order_table[f][ORD_CABIN])
                    return DIR_UP;
            for (int f = TOP_FLOOR; f >= 0; f--)
                if (order_table[f][ORD_DOWN] || order_table[f][ORD_CABIN])
                    return (f > here) ? DIR_UP : DIR_DOWN;
            for (int f = 0; f < here; f++)
                if (order_table[f][ORD_UP])
                    return DIR_DOWN;
        end else begin
            for (int f = here; f >= 0; f--)
                if (order_table[f][ORD_DOWN] || order_table[f][ORD_CABIN])
                    return DIR_DOWN;
            for (int f = 0; f <= TOP_FLOOR; f++)
                if (order_table[f][ORD_UP] || order_table[f][ORD_CABIN])
                    return (f < here) ? DIR_DOWN : DIR_UP;
            for (int f = TOP_FLOOR; f > here; f--)
                if (order_table[f][ORD_DOWN])
                    return DIR_UP;
        end
        return DIR_KEEP;
    endfunction

    // any order below the car (or at it when going up) means restart downward
    function automatic logic [1:0] restart_dir(input int here, input logic down);
        int limit;
        limit = down ? here : here + 1;
        for (int f = 0; f < limit && f < FLOOR_COUNT; f++)
            if (|order_table[f])
                return DIR_DOWN;
        return DIR_UP;
    endfunction

    function automatic t_result dispatch_item(input t_item it);
        t_result r;
        bit in_range;
        int here;
        logic [2:0] want;
        in_range = int'(it.floor) < FLOOR_COUNT;
        here = in_range ? int'(it.floor) : TOP_FLOOR;
        case (it.action)
            ACT_SET: begin
                if (in_range && it.button <= BTN_CABIN &&
                    !(it.button == BTN_UP && here == TOP_FLOOR) &&
                    !(it.button == BTN_DOWN && here == 0))
                    order_table[here][it.button] = 1'b1;
            end
            ACT_CLR_FLOOR: begin
                if (in_range)
                    order_table[here] = '0;
            end
            ACT_CLR_ALL: begin
                for (int f = 0; f < FLOOR_COUNT; f++)
                    order_table[f] = '0;
            end
            default: ;
        endcase
        want = '0;
        want[ORD_CABIN] = 1'b1;
        if (it.travel_down)
            want[ORD_DOWN] = 1'b1;
        else
            want[ORD_UP] = 1'b1;
        r = '0;
        r.stop_here = in_range && |(order_table[here] & want);
        r.orders_empty = 1'b1;
        for (int f = 0; f < FLOOR_COUNT; f++) begin
            if (|order_table[f])
                r.orders_empty = 1'b0;
            if (f < 4)
                r.order_lamps[3*f +: 3] = order_table[f];
        end
        r.next_direction = sweep_dir(here, it.travel_down);
        r.restart_direction = restart_dir(here, it.travel_down) == DIR_DOWN;
        return r;
    endfunction

    task automatic send_item(input logic [1:0] action, input logic [1:0] floor,
                             input logic [1:0] button, input logic travel_down);
        t_item it;
        t_result r;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.action      <= action;
        in_ch.floor       <= floor;
        in_ch.button      <= button;
        in_ch.travel_down <= travel_down;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        it.action = action;
        it.floor = floor;
        it.button = button;
        it.travel_down = travel_down;
        r = dispatch_item(it);
        owed_results.push_back(r);
        dir_seen[r.next_direction]++;
        items_sent++;
    endtask

    // stall bursts on the result side
    initial begin
        int stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 10) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (owed_results.size() == 0) begin
                $error("result with no item outstanding");
                fail_count++;
            end else begin
                want = owed_results.pop_front();
                results_checked++;
                if (out_ch.stop_here !== want.stop_here) begin
                    $error("stop_here: expected %0d, got %0d",
                           want.stop_here, out_ch.stop_here);
                    fail_count++;
                end
                if (out_ch.orders_empty !== want.orders_empty) begin
                    $error("orders_empty: expected %0d, got %0d",
                           want.orders_empty, out_ch.orders_empty);
                    fail_count++;
                end
                if (out_ch.next_direction !== want.next_direction) begin
                    $error("next_direction: expected %0d, got %0d",
                           want.next_direction, out_ch.next_direction);
                    fail_count++;
                end
                if (out_ch.restart_direction !== want.restart_direction) begin
                    $error("restart_direction: expected %0d, got %0d",
                           want.restart_direction, out_ch.restart_direction);
                    fail_count++;
                end
                if (out_ch.order_lamps !== want.order_lamps) begin
                    $error("order_lamps: expected %03h, got %03h",
                           want.order_lamps, out_ch.order_lamps);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_empty_table();
        send_item(ACT_EVAL, 2'd0, BTN_UP, 1'b0);
        send_item(ACT_EVAL, 2'd3, BTN_CABIN, 1'b1);
    endtask

    // hall calls that do not exist and the unused button code leave the table empty
    task automatic test_missing_hall_calls();
        send_item(ACT_SET, 2'd3, BTN_UP, 1'b0);
        send_item(ACT_SET, 2'd0, BTN_DOWN, 1'b1);
        send_item(ACT_SET, 2'd2, BTN_NONE, 1'b0);
    endtask

    task automatic test_orders_and_clears();
        send_item(ACT_SET, 2'd3, BTN_CABIN, 1'b0);
        send_item(ACT_SET, 2'd2, BTN_DOWN, 1'b0);
        send_item(ACT_SET, 2'd1, BTN_UP, 1'b1);
        send_item(ACT_SET, 2'd3, BTN_DOWN, 1'b1);
        send_item(ACT_EVAL, 2'd2, BTN_UP, 1'b1);
        send_item(ACT_CLR_FLOOR, 2'd2, BTN_NONE, 1'b1);
        send_item(ACT_CLR_FLOOR, 2'd3, BTN_UP, 1'b0);
        send_item(ACT_SET, 2'd0, BTN_CABIN, 1'b1);
        send_item(ACT_CLR_ALL, 2'd3, BTN_NONE, 1'b1);
    endtask

    // one case for each pass of the sweep in both travel directions
    task automatic test_sweep_passes();
        send_item(ACT_SET, 2'd1, BTN_DOWN, 1'b0);
        send_item(ACT_EVAL, 2'd2, BTN_UP, 1'b0);
        send_item(ACT_CLR_ALL, 2'd0, BTN_UP, 1'b0);
        send_item(ACT_SET, 2'd0, BTN_UP, 1'b0);
        send_item(ACT_EVAL, 2'd2, BTN_UP, 1'b0);
        send_item(ACT_CLR_ALL, 2'd1, BTN_DOWN, 1'b1);
        send_item(ACT_SET, 2'd3, BTN_DOWN, 1'b1);
        send_item(ACT_EVAL, 2'd1, BTN_DOWN, 1'b1);
        send_item(ACT_SET, 2'd2, BTN_UP, 1'b1);
        send_item(ACT_EVAL, 2'd3, BTN_CABIN, 1'b0);
    endtask

    task automatic test_random_orders(input int count);
        int pick;
        logic [1:0] action;
        logic [1:0] button;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                action = ACT_SET;
            else if (pick < 60)
                action = ACT_CLR_FLOOR;
            else if (pick < 65)
                action = ACT_CLR_ALL;
            else
                action = ACT_EVAL;
            if ($urandom_range(0, 9) == 0)
                button = BTN_NONE;
            else
                button = 2'($urandom_range(0, 2));
            send_item(action, 2'($urandom_range(0, 3)), button, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        int waited;
        fail_count = 0;
        items_sent = 0;
        results_checked = 0;
        idle_on = 1'b1;
        for (int f = 0; f < FLOOR_COUNT; f++)
            order_table[f] = '0;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.action      <= ACT_EVAL;
        in_ch.floor       <= '0;
        in_ch.button      <= BTN_UP;
        in_ch.travel_down <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_missing_hall_calls();
        test_orders_and_clears();
        test_sweep_passes();
        test_random_orders(1080);
        idle_on = 1'b0;
        test_random_orders(200);
        in_ch.valid <= 1'b0;

        waited = 0;
        while (owed_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (6) @(posedge i_clk);
        if (owed_results.size() != 0) begin
            $error("%0d results never arrived", owed_results.size());
            fail_count++;
        end

        $display("sent %0d items, checked %0d results", items_sent, results_checked);
        $display("next direction up/down/keep predicted %0d/%0d/%0d times",
                 dir_seen[DIR_UP], dir_seen[DIR_DOWN], dir_seen[DIR_KEEP]);
        if (fail_count == 0)
            $display("elevator_order_dispatcher_core_tb passed");
        else
            $display("elevator_order_dispatcher_core_tb failed");
        $finish;
    end

endmodule
